FILE: src/elastic_stress_von_mises_macros.svh
// assertion macros shared by the elastic stress block
// no dependencies; included by files that carry concurrent assertions
`ifndef ELASTIC_STRESS_VON_MISES_MACROS_SVH
`define ELASTIC_STRESS_VON_MISES_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define EVM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled while reset is low
`define EVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

FILE: src/evm_pkg.sv
// shared types and constants of the elastic stress / von mises block
// no dependencies; used by the interfaces, the root pipeline and the top level
`timescale 1ns / 1ps
package evm_pkg;

    localparam int GRAD_W   = 32;
    localparam int STRESS_W = 64;
    localparam int ROOT_W   = 64;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAME_LAMBDA   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR_MODULUS = 2'd2;

    // filter mode codes
    localparam logic [1:0] FILT_KEEP_ALL       = 2'd0;
    localparam logic [1:0] FILT_DROP_DISP      = 2'd1;
    localparam logic [1:0] FILT_DROP_ANY       = 2'd2;
    localparam logic [1:0] FILT_DROP_ANY_ALIAS = 2'd3;

    localparam logic [STRESS_W-1:0] SMAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [STRESS_W-1:0] SMIN64 = 64'h8000_0000_0000_0000;

    // result fields that ride alongside the square root
    typedef struct packed {
        logic signed [GRAD_W-1:0]   strain_xx;
        logic signed [GRAD_W-1:0]   strain_yy;
        logic signed [GRAD_W-1:0]   strain_xy;
        logic signed [STRESS_W-1:0] stress_x;
        logic signed [STRESS_W-1:0] stress_y;
        logic signed [STRESS_W-1:0] stress_xy;
    } t_side;

endpackage

FILE: src/evm_stream_if.sv
// valid/ready stream interfaces for particle items and results
// depends on evm_pkg for field widths
`timescale 1ns / 1ps
interface evm_in_if import evm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] grad_ux_x;
    logic signed [GRAD_W-1:0] grad_ux_y;
    logic signed [GRAD_W-1:0] grad_uy_x;
    logic signed [GRAD_W-1:0] grad_uy_y;
    logic                     fixed_disp_x;
    logic                     fixed_disp_y;
    logic                     applied_force_x;
    logic                     applied_force_y;

    modport source (
        output valid, grad_ux_x, grad_ux_y, grad_uy_x, grad_uy_y,
               fixed_disp_x, fixed_disp_y, applied_force_x, applied_force_y,
        input  ready
    );
    modport sink (
        input  valid, grad_ux_x, grad_ux_y, grad_uy_x, grad_uy_y,
               fixed_disp_x, fixed_disp_y, applied_force_x, applied_force_y,
        output ready
    );
endinterface

interface evm_out_if import evm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [GRAD_W-1:0]   strain_xx;
    logic signed [GRAD_W-1:0]   strain_yy;
    logic signed [GRAD_W-1:0]   strain_xy;
    logic signed [STRESS_W-1:0] stress_x;
    logic signed [STRESS_W-1:0] stress_y;
    logic signed [STRESS_W-1:0] stress_xy;
    logic        [ROOT_W-1:0]   von_mises;

    modport source (
        output valid, strain_xx, strain_yy, strain_xy, stress_x, stress_y, stress_xy,
               von_mises,
        input  ready
    );
    modport sink (
        input  valid, strain_xx, strain_yy, strain_xy, stress_x, stress_y, stress_xy,
               von_mises,
        output ready
    );
endinterface

FILE: src/evm_isqrt.sv
// pipelined integer square root, one root bit per register stage
// depends on evm_pkg; side fields travel with each radicand
`timescale 1ns / 1ps
module evm_isqrt import evm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [RAD_W-1:0] i_rad,
    input  logic             i_sat,
    input  t_side            i_side,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ROOT_W-1:0] o_root,
    output t_side            o_side
);

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        logic              sat;
    } t_lane;

    function automatic t_lane sqrt_step(input t_lane l);
        logic [REM_W+1:0] rq;
        logic [REM_W+1:0] tq;
        t_lane            n;
        rq = {l.rem, l.rad[RAD_W-1 -: 2]};
        tq = {2'b00, l.root, 2'b01};
        n  = l;
        if (rq >= tq) begin
            n.rem  = REM_W'(rq - tq);
            n.root = {l.root[ROOT_W-2:0], 1'b1};
        end else begin
            n.rem  = REM_W'(rq);
            n.root = {l.root[ROOT_W-2:0], 1'b0};
        end
        n.rad = {l.rad[RAD_W-3:0], 2'b00};
        return n;
    endfunction

    t_lane              r_lane [ROOT_W];
    t_side              r_side [ROOT_W];
    logic [ROOT_W-1:0]  r_v;
    logic [ROOT_W:0]    w_en;
    t_lane              w_first;

    always_comb begin
        w_en[ROOT_W] = i_ready;
        for (int k = ROOT_W - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_comb begin
        w_first.rem  = '0;
        w_first.root = '0;
        w_first.rad  = i_rad;
        w_first.sat  = i_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < ROOT_W; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_lane[0] <= sqrt_step(w_first);
            r_side[0] <= i_side;
        end
        for (int k = 1; k < ROOT_W; k++) begin
            if (w_en[k]) begin
                r_lane[k] <= sqrt_step(r_lane[k-1]);
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_lane[ROOT_W-1].sat ? '1 : r_lane[ROOT_W-1].root;
    assign o_side  = r_side[ROOT_W-1];

endmodule

FILE: src/elastic_stress_von_mises.sv
// top level: strains, linear elastic stresses and von mises stress per particle
// depends on evm_pkg, evm_stream_if, evm_isqrt and the assertion macro header
//
//  channel    dir   handshake          payload
//  i_item     in    valid / ready      four gradients (Q1.30), four boundary flags
//  o_result   out   valid / ready      three strains, three stresses, von mises
//  i_cfg_*    in    write enable only  filter mode, lambda, mu
//
// one particle enters per cycle while the pipeline is not stalled; ten arithmetic stages
// are followed by 64 square root stages, one root bit per stage, which set the depth
// every stage holds its own valid bit, so bubbles close up under an output stall
// and input is only refused when every stage is full and the result is not taken
// synchronous active-low reset clears valid bits and configuration registers
`timescale 1ns / 1ps
`include "elastic_stress_von_mises_macros.svh"
module elastic_stress_von_mises import evm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    evm_in_if.sink                i_item,
    evm_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int NSTG = 10;

    // signed sum of two sign-magnitude terms, saturated to 64 bits
    function automatic logic [STRESS_W-1:0] sat_sum(input logic n1, input logic [63:0] m1,
                                                     input logic n2, input logic [63:0] m2);
        logic [64:0] mag;
        logic        neg;
        if (n1 == n2) begin
            mag = {1'b0, m1} + {1'b0, m2};
            neg = n1;
        end else if (m1 >= m2) begin
            mag = {1'b0, m1 - m2};
            neg = n1;
        end else begin
            mag = {1'b0, m2 - m1};
            neg = n2;
        end
        if (!neg) begin
            return (mag > {1'b0, SMAX64}) ? SMAX64 : mag[63:0];
        end
        return (mag > {1'b0, SMIN64}) ? SMIN64 : (~mag[63:0] + 64'd1);
    endfunction

    // configuration
    logic [1:0]        r_filter_mode;
    logic [GRAD_W-1:0] r_lambda;
    logic [GRAD_W-1:0] r_mu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode <= FILT_KEEP_ALL;
            r_lambda      <= '0;
            r_mu          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FILTER_MODE:   r_filter_mode <= i_cfg_data[1:0];
                REG_LAME_LAMBDA:   r_lambda      <= i_cfg_data;
                REG_SHEAR_MODULUS: r_mu          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stall chain: a stage moves when empty or when the next one moves
    logic [NSTG:1]   r_v;
    logic [NSTG+1:1] w_en;
    logic            w_sq_ready;

    always_comb begin
        w_en[NSTG+1] = w_sq_ready;
        for (int k = NSTG; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_item.ready = w_en[1];

    // particle filter on the incoming flags
    logic w_keep;
    logic w_disp;
    logic w_any;
    assign w_disp = i_item.fixed_disp_x || i_item.fixed_disp_y;
    assign w_any  = w_disp || i_item.applied_force_x || i_item.applied_force_y;

    always_comb begin
        case (r_filter_mode) inside
            FILT_KEEP_ALL:                      w_keep = 1'b1;
            FILT_DROP_DISP:                     w_keep = !w_disp;
            FILT_DROP_ANY, FILT_DROP_ANY_ALIAS: w_keep = !w_any;
            default:                            w_keep = !w_any;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            // dropped particles are taken but never enter the pipe
            if (w_en[1]) begin
                r_v[1] <= i_item.valid && w_keep;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // side fields per stage
    t_side r_side [1:NSTG];

    // stage 1: strain sums
    logic signed [GRAD_W:0] w_sum;
    logic signed [GRAD_W:0] w_shear;
    t_side                  w_side1;
    logic signed [GRAD_W:0] r_sum1;
    logic signed [GRAD_W:0] r_shear1;

    assign w_sum   = {i_item.grad_ux_x[GRAD_W-1], i_item.grad_ux_x}
                   + {i_item.grad_uy_y[GRAD_W-1], i_item.grad_uy_y};
    assign w_shear = {i_item.grad_ux_y[GRAD_W-1], i_item.grad_ux_y}
                   + {i_item.grad_uy_x[GRAD_W-1], i_item.grad_uy_x};

    always_comb begin
        w_side1           = '0;
        w_side1.strain_xx = i_item.grad_ux_x;
        w_side1.strain_yy = i_item.grad_uy_y;
        // half the shear sum, rounded toward minus infinity
        w_side1.strain_xy = w_shear[GRAD_W:1];
    end

    // stage 2: magnitudes and signs
    logic [GRAD_W:0]   r_ms2;
    logic [GRAD_W:0]   r_mq2;
    logic [GRAD_W-1:0] r_mx2;
    logic [GRAD_W-1:0] r_my2;
    logic              r_ns2, r_nx2, r_ny2, r_nq2;

    // stage 3: products with the lame parameters
    logic [63:0] r_lam3, r_px3, r_py3, r_pq3;
    logic        r_ns3, r_nx3, r_ny3, r_nq3;
    logic [63:0] w_mux, w_muy, w_lam, w_muq;

    assign w_lam = 64'(r_lambda) * 64'(r_ms2[GRAD_W-1:0]);
    assign w_muq = 64'(r_mu) * 64'(r_mq2[GRAD_W-1:0]);
    assign w_mux = 64'(r_mu) * 64'(r_mx2);
    assign w_muy = 64'(r_mu) * 64'(r_my2);

    // stage 5: stress magnitudes
    logic [63:0] r_a5, r_b5, r_c5;
    logic        r_na5, r_nb5;

    // stage 6: squared operands, chosen so no term goes negative
    logic [63:0] r_sq1_6, r_sq2_6, r_a6, r_b6, r_c6;
    logic        w_case1;
    logic [63:0] w_d;
    assign w_case1 = (r_na5 == r_nb5) || (r_a5 == '0) || (r_b5 == '0);
    assign w_d     = (r_a5 >= r_b5) ? (r_a5 - r_b5) : (r_b5 - r_a5);

    // stage 7: 32x32 partial products of the four squares/products
    logic [63:0] r_pp7 [4][4];
    logic [63:0] w_opx [4];
    logic [63:0] w_opy [4];
    assign w_opx[0] = r_sq1_6;
    assign w_opy[0] = r_sq1_6;
    assign w_opx[1] = r_sq2_6;
    assign w_opy[1] = r_sq2_6;
    assign w_opx[2] = r_a6;
    assign w_opy[2] = r_b6;
    assign w_opx[3] = r_c6;
    assign w_opy[3] = r_c6;

    // stage 8: full 128-bit products
    logic [RAD_W-1:0] r_prod8 [4];

    // stage 9 and 10: radicand and overflow
    logic [RAD_W:0]   r_s01_9;
    logic [RAD_W+1:0] r_s23_9;
    logic [RAD_W+1:0] w_total;
    logic [RAD_W-1:0] r_rad10;
    logic             r_sat10;
    assign w_total = {1'b0, r_s01_9} + r_s23_9;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_side[1] <= w_side1;
            r_sum1    <= w_sum;
            r_shear1  <= w_shear;
        end
        // stage 4 loads its own side fields below
        for (int k = 2; k <= NSTG; k++) begin
            if (k != 4 && w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
        if (w_en[2]) begin
            r_ns2 <= r_sum1[GRAD_W];
            r_nq2 <= r_shear1[GRAD_W];
            r_nx2 <= r_side[1].strain_xx[GRAD_W-1];
            r_ny2 <= r_side[1].strain_yy[GRAD_W-1];
            r_ms2 <= r_sum1[GRAD_W] ? (GRAD_W+1)'(-r_sum1) : r_sum1;
            r_mq2 <= r_shear1[GRAD_W] ? (GRAD_W+1)'(-r_shear1) : r_shear1;
            r_mx2 <= r_side[1].strain_xx[GRAD_W-1] ? GRAD_W'(-r_side[1].strain_xx)
                                                    : r_side[1].strain_xx;
            r_my2 <= r_side[1].strain_yy[GRAD_W-1] ? GRAD_W'(-r_side[1].strain_yy)
                                                    : r_side[1].strain_yy;
        end
        if (w_en[3]) begin
            // a magnitude of exactly 2^32 has a zero low word
            r_lam3 <= r_ms2[GRAD_W] ? {r_lambda, 32'd0} : w_lam;
            r_pq3  <= r_mq2[GRAD_W] ? {r_mu, 32'd0} : w_muq;
            r_px3  <= {w_mux[62:0], 1'b0};
            r_py3  <= {w_muy[62:0], 1'b0};
            r_ns3  <= r_ns2;
            r_nx3  <= r_nx2;
            r_ny3  <= r_ny2;
            r_nq3  <= r_nq2;
        end
        if (w_en[4]) begin
            r_side[4].strain_xx <= r_side[3].strain_xx;
            r_side[4].strain_yy <= r_side[3].strain_yy;
            r_side[4].strain_xy <= r_side[3].strain_xy;
            r_side[4].stress_x  <= sat_sum(r_ns3, r_lam3, r_nx3, r_px3);
            r_side[4].stress_y  <= sat_sum(r_ns3, r_lam3, r_ny3, r_py3);
            r_side[4].stress_xy <= sat_sum(r_nq3, r_pq3, 1'b0, 64'd0);
        end
        if (w_en[5]) begin
            r_na5 <= r_side[4].stress_x[63];
            r_nb5 <= r_side[4].stress_y[63];
            r_a5  <= r_side[4].stress_x[63] ? 64'(-r_side[4].stress_x) : r_side[4].stress_x;
            r_b5  <= r_side[4].stress_y[63] ? 64'(-r_side[4].stress_y) : r_side[4].stress_y;
            r_c5  <= r_side[4].stress_xy[63] ? 64'(-r_side[4].stress_xy)
                                             : r_side[4].stress_xy;
        end
        if (w_en[6]) begin
            r_sq1_6 <= w_case1 ? w_d : r_a5;
            r_sq2_6 <= w_case1 ? 64'd0 : r_b5;
            r_a6    <= r_a5;
            r_b6    <= r_b5;
            r_c6    <= r_c5;
        end
        if (w_en[7]) begin
            for (int j = 0; j < 4; j++) begin
                r_pp7[j][0] <= 64'(w_opx[j][31:0])  * 64'(w_opy[j][31:0]);
                r_pp7[j][1] <= 64'(w_opx[j][31:0])  * 64'(w_opy[j][63:32]);
                r_pp7[j][2] <= 64'(w_opx[j][63:32]) * 64'(w_opy[j][31:0]);
                r_pp7[j][3] <= 64'(w_opx[j][63:32]) * 64'(w_opy[j][63:32]);
            end
        end
        if (w_en[8]) begin
            for (int j = 0; j < 4; j++) begin
                r_prod8[j] <= {r_pp7[j][3], r_pp7[j][0]}
                            + {32'd0, r_pp7[j][1], 32'd0}
                            + {32'd0, r_pp7[j][2], 32'd0};
            end
        end
        if (w_en[9]) begin
            r_s01_9 <= {1'b0, r_prod8[0]} + {1'b0, r_prod8[1]};
            // a*b plus three times the shear square
            r_s23_9 <= {2'b00, r_prod8[2]} + {2'b00, r_prod8[3]} + {1'b0, r_prod8[3], 1'b0};
        end
        if (w_en[10]) begin
            r_rad10 <= w_total[RAD_W-1:0];
            r_sat10 <= |w_total[RAD_W+1:RAD_W];
        end
    end

    // square root pipeline and output
    logic  w_sq_valid;
    t_side w_out_side;

    evm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[NSTG]),
        .o_ready (w_sq_ready),
        .i_rad   (r_rad10),
        .i_sat   (r_sat10),
        .i_side  (r_side[NSTG]),
        .o_valid (w_sq_valid),
        .i_ready (o_result.ready),
        .o_root  (o_result.von_mises),
        .o_side  (w_out_side)
    );

    assign o_result.valid     = w_sq_valid;
    assign o_result.strain_xx = w_out_side.strain_xx;
    assign o_result.strain_yy = w_out_side.strain_yy;
    assign o_result.strain_xy = w_out_side.strain_xy;
    assign o_result.stress_x  = w_out_side.stress_x;
    assign o_result.stress_y  = w_out_side.stress_y;
    assign o_result.stress_xy = w_out_side.stress_xy;

    // input is refused only when the result side is stalled
    `EVM_ASSERT_NOW(a_stall_source, i_clk, i_rst_n, !i_item.ready, o_result.valid && !o_result.ready)
    // a particle with fixed_disp_x set never reaches the first stage in drop-displacement mode
    `EVM_ASSERT_NEXT(a_drop_disp, i_clk, i_rst_n, i_item.valid && i_item.ready && r_filter_mode == FILT_DROP_DISP && i_item.fixed_disp_x, !r_v[1])
    // the last arithmetic stage holds its item while the root pipe refuses it
    `EVM_ASSERT_NEXT(a_hold_last, i_clk, i_rst_n, r_v[NSTG] && !w_sq_ready, r_v[NSTG])

endmodule

FILE: tb/sv/elastic_stress_von_mises_test.sv
// self-checking testbench for the elastic stress / von mises block
// depends on evm_pkg, evm_stream_if and elastic_stress_von_mises
`timescale 1ns / 1ps
module elastic_stress_von_mises_test;
    import evm_pkg::*;

    typedef struct {
        logic signed [GRAD_W-1:0]   strain_xx;
        logic signed [GRAD_W-1:0]   strain_yy;
        logic signed [GRAD_W-1:0]   strain_xy;
        logic signed [STRESS_W-1:0] stress_x;
        logic signed [STRESS_W-1:0] stress_y;
        logic signed [STRESS_W-1:0] stress_xy;
        logic        [ROOT_W-1:0]   von_mises;
    } t_particle_result;

    typedef struct {
        logic signed [GRAD_W-1:0] gxx, gxy, gyx, gyy;
        logic dx, dy, fx, fy;
    } t_particle;

    // holds the register copy and the queue of pending particle results
    class stress_scoreboard;
        logic [1:0]  filter_mode;
        logic [31:0] lambda_reg;
        logic [31:0] mu_reg;
        t_particle_result pending[$];
        int errors;

        function new();
            filter_mode = FILT_KEEP_ALL;
            lambda_reg  = '0;
            mu_reg      = '0;
            errors      = 0;
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // signed exact sum clamped to the 64-bit range
        function logic signed [63:0] clamp64(logic signed [67:0] v);
            if (v > $signed({4'b0, SMAX64})) return SMAX64;
            if (v < -$signed({4'b0, SMIN64})) return SMIN64;
            return v[63:0];
        endfunction

        function logic [63:0] root_floor(logic [127:0] v);
            logic [63:0]  r;
            logic [63:0]  t;
            logic [127:0] sq;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                t  = r | (64'd1 << b);
                sq = 128'(t) * 128'(t);
                if (sq <= v) r = t;
            end
            return r;
        endfunction

        function void note(t_particle p);
            t_particle_result e;
            logic signed [33:0]  vol;
            logic signed [32:0]  shear;
            logic [33:0]         vol_mag;
            logic [32:0]         shear_mag;
            logic [31:0]         mx, my;
            logic [97:0]         lam_wide;
            logic signed [67:0]  lam_term, t_x, t_y, t_s;
            logic [64:0]         m2;
            logic signed [131:0] ax, ay, as, q;
            if (filter_mode == FILT_DROP_DISP && (p.dx || p.dy)) return;
            if ((filter_mode == FILT_DROP_ANY || filter_mode == FILT_DROP_ANY_ALIAS)
                && (p.dx || p.dy || p.fx || p.fy)) return;
            vol   = 34'(p.gxx) + 34'(p.gyy);
            shear = 33'(p.gxy) + 33'(p.gyx);
            vol_mag   = vol < 0 ? 34'(-vol) : 34'(vol);
            shear_mag = shear < 0 ? 33'(-shear) : 33'(shear);
            mx = p.gxx < 0 ? 32'(-33'(p.gxx)) : 32'(p.gxx);
            my = p.gyy < 0 ? 32'(-33'(p.gyy)) : 32'(p.gyy);
            // lambda term wraps at 64 bits before the sum
            lam_wide = lambda_reg * vol_mag;
            lam_term = $signed({4'b0, lam_wide[63:0]});
            if (vol < 0) lam_term = -lam_term;
            m2  = 65'(2) * mu_reg * mx;
            t_x = $signed({3'b0, m2});
            if (p.gxx < 0) t_x = -t_x;
            m2  = 65'(2) * mu_reg * my;
            t_y = $signed({3'b0, m2});
            if (p.gyy < 0) t_y = -t_y;
            t_s = $signed({4'b0, 64'(mu_reg * shear_mag)});
            if (shear < 0) t_s = -t_s;
            e.strain_xx = p.gxx;
            e.strain_yy = p.gyy;
            e.strain_xy = 32'(shear >>> 1);
            e.stress_x  = clamp64(lam_term + t_x);
            e.stress_y  = clamp64(lam_term + t_y);
            e.stress_xy = clamp64(t_s);
            ax = e.stress_x;
            ay = e.stress_y;
            as = e.stress_xy;
            q  = ax * ax + ay * ay - ax * ay + 3 * as * as;
            if (q[131:128] != 0) e.von_mises = '1;
            else e.von_mises = root_floor(q[127:0]);
            pending = {pending, e};
        endfunction

        task check(t_particle_result g);
            t_particle_result e;
            if (pending.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (g.strain_xx !== e.strain_xx) report("strain_xx", 64'(g.strain_xx), 64'(e.strain_xx));
            if (g.strain_yy !== e.strain_yy) report("strain_yy", 64'(g.strain_yy), 64'(e.strain_yy));
            if (g.strain_xy !== e.strain_xy) report("strain_xy", 64'(g.strain_xy), 64'(e.strain_xy));
            if (g.stress_x !== e.stress_x) report("stress_x", g.stress_x, e.stress_x);
            if (g.stress_y !== e.stress_y) report("stress_y", g.stress_y, e.stress_y);
            if (g.stress_xy !== e.stress_xy) report("stress_xy", g.stress_xy, e.stress_xy);
            if (g.von_mises !== e.von_mises) report("von_mises", g.von_mises, e.von_mises);
        endtask
    endclass

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 120;   // pipeline depth is 74

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    int cycle_count = 0;
    bit out_stall_long = 1'b0;

    evm_in_if  item_if ();
    evm_out_if result_if ();

    stress_scoreboard sb = new();

    elastic_stress_von_mises u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if.sink),
        .o_result   (result_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("elastic_stress_von_mises_test: done, errors");
            $finish;
        end
    end

    // receiver side: random backpressure, mostly short, sometimes long
    initial result_if.ready = 1'b0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else if (out_stall_long) begin
            result_if.ready <= ($urandom_range(0, 39) == 0);
        end else begin
            result_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // switch between short-stall and long-stall stretches
    always @(posedge i_clk) begin
        if ($urandom_range(0, 499) == 0) out_stall_long <= ~out_stall_long;
    end

    // result transactions are sampled mid-cycle, away from the driving edge
    always @(negedge i_clk) begin
        t_particle_result g;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            g.strain_xx = result_if.strain_xx;
            g.strain_yy = result_if.strain_yy;
            g.strain_xy = result_if.strain_xy;
            g.stress_x  = result_if.stress_x;
            g.stress_y  = result_if.stress_y;
            g.stress_xy = result_if.stress_xy;
            g.von_mises = result_if.von_mises;
            sb.check(g);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_FILTER_MODE:   sb.filter_mode = data[1:0];
            REG_LAME_LAMBDA:   sb.lambda_reg  = data;
            REG_SHEAR_MODULUS: sb.mu_reg      = data;
            default: ;
        endcase
    endtask

    // stop sending, wait until all results are in, then let the pipeline empty
    task automatic drain();
        item_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_params(logic [1:0] mode, logic [31:0] lam, logic [31:0] mu);
        drain();
        write_reg(REG_FILTER_MODE, 32'(mode));
        write_reg(REG_LAME_LAMBDA, lam);
        write_reg(REG_SHEAR_MODULUS, mu);
    endtask

    // one input transaction, with an optional idle gap before it
    task automatic send_particle(t_particle p, int gap);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid           <= 1'b1;
        item_if.grad_ux_x       <= p.gxx;
        item_if.grad_ux_y       <= p.gxy;
        item_if.grad_uy_x       <= p.gyx;
        item_if.grad_uy_y       <= p.gyy;
        item_if.fixed_disp_x    <= p.dx;
        item_if.fixed_disp_y    <= p.dy;
        item_if.applied_force_x <= p.fx;
        item_if.applied_force_y <= p.fy;
        do @(negedge i_clk); while (!item_if.ready);
        sb.note(p);
        @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [31:0] pick_grad();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(signed'($urandom_range(0, 2048)) - 1024);
            3: return $urandom() >>> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_param();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return '0;
            2: return $urandom_range(0, 255);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_particle rand_particle();
        t_particle p;
        p.gxx = pick_grad();
        p.gxy = pick_grad();
        p.gyx = pick_grad();
        p.gyy = pick_grad();
        // flags mostly clear so that filtering modes still pass results
        p.dx = ($urandom_range(0, 4) == 0);
        p.dy = ($urandom_range(0, 4) == 0);
        p.fx = ($urandom_range(0, 4) == 0);
        p.fy = ($urandom_range(0, 4) == 0);
        return p;
    endfunction

    function automatic t_particle mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                     logic [31:0] d, logic [3:0] flags);
        t_particle p;
        p.gxx = a;
        p.gxy = b;
        p.gyx = c;
        p.gyy = d;
        {p.dx, p.dy, p.fx, p.fy} = flags;
        return p;
    endfunction

    initial begin
        logic [31:0] lam_set;
        logic [31:0] mu_set;
        item_if.valid           <= 1'b0;
        item_if.grad_ux_x       <= '0;
        item_if.grad_ux_y       <= '0;
        item_if.grad_uy_x       <= '0;
        item_if.grad_uy_y       <= '0;
        item_if.fixed_disp_x    <= 1'b0;
        item_if.fixed_disp_y    <= 1'b0;
        item_if.applied_force_x <= 1'b0;
        item_if.applied_force_y <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: all stresses come out zero
        send_particle(mk(32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000, 32'h4000_0000, 4'hF), 0);

        // largest parameters, extremes of every gradient; stresses saturate on the extremes
        set_params(FILT_KEEP_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_particle(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'h0), 0);
        send_particle(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 4'h0), 0);
        send_particle(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 4'h0), 1);
        send_particle(mk(32'h0, 32'h0, 32'h0, 32'h0, 4'h0), 0);
        // odd negative shear sum: halving rounds toward minus infinity
        send_particle(mk(32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0), 0);
        send_particle(mk(32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 4'h0), 0);

        // moderate parameters: opposite-sign stresses, no saturation
        set_params(FILT_KEEP_ALL, 32'd3, 32'd7);
        send_particle(mk(32'h4000_0000, 32'h0000_0001, 32'h0, 32'hC000_0000, 4'h0), 0);
        send_particle(mk(32'hC000_0000, 32'h1000_0000, 32'h2000_0001, 32'h4000_0000, 4'h0), 0);

        // filter modes: drop-displacement against each flag, drop-any and its alias against one force flag each
        set_params(FILT_DROP_DISP, 32'd1000, 32'd500);
        for (int f = 0; f < 16; f += 5)
            send_particle(mk(32'h100, 32'h200, 32'h300, 32'h400, 4'(f)), 0);
        send_particle(mk(32'h100, 32'h200, 32'h300, 32'h400, 4'b0010), 0);
        set_params(FILT_DROP_ANY, 32'd1000, 32'd500);
        send_particle(mk(32'h100, 32'h200, 32'h300, 32'h400, 4'b0001), 0);
        send_particle(mk(32'h100, 32'h200, 32'h300, 32'h400, 4'b0000), 0);
        set_params(FILT_DROP_ANY_ALIAS, 32'd1000, 32'd500);
        send_particle(mk(32'h100, 32'h200, 32'h300, 32'h400, 4'b0010), 0);
        send_particle(mk(32'h100, 32'h200, 32'h300, 32'h400, 4'b0000), 0);

        // random phases over a spread of settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin lam_set = 32'hFFFF_FFFF; mu_set = 32'hFFFF_FFFF; end
                1: begin lam_set = '0; mu_set = '0; end
                2: begin lam_set = '0; mu_set = 32'hFFFF_FFFF; end
                default: begin lam_set = pick_param(); mu_set = pick_param(); end
            endcase
            set_params(2'(ph % 4), lam_set, mu_set);
            for (int n = 0; n < 190; n++) begin
                // one hold-off mid-stream until the pipeline has delivered everything
                if (ph == 3 && n == 90) begin
                    item_if.valid <= 1'b0;
                    @(posedge i_clk);
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
                if (ph == 5 && n < 60) send_particle(rand_particle(), 0);
                else send_particle(rand_particle(), pick_gap());
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("elastic_stress_von_mises_test: done, clean");
        end else begin
            $display("elastic_stress_von_mises_test: done, errors");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/evm_pkg.sv
src/evm_stream_if.sv
src/evm_isqrt.sv
src/elastic_stress_von_mises.sv
tb/sv/elastic_stress_von_mises_test.sv
